// File: design/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared sizes and the shift-and-add-3 step for the binary to decimal ASCII
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W         = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int BCD_W           = NUM_DIGITS * 4;
  localparam int STATE_W         = BCD_W + VALUE_W;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;
  localparam int DIGIT_IDX_W     = $clog2(NUM_DIGITS);
  localparam int CHAR_W          = 6;
  localparam int TDATA_OUT_W     = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [STATE_W-1:0] dabble_state_t;

  // One double-dabble bit: fix up BCD nibbles >= 5, then shift the whole word.
  function automatic dabble_state_t dabble_step(dabble_state_t x);
    dabble_state_t y;
    y = x;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      if (y[VALUE_W + 4*j +: 4] >= 4'd5) begin
        y[VALUE_W + 4*j +: 4] = y[VALUE_W + 4*j +: 4] + 4'd3;
      end
    end
    return {y[STATE_W-2:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

// File: design/b2da_stage.sv
// ----------------------------------------------------------------------------
// b2da_stage
// One pipeline stage of the converter: four shift-and-add-3 steps, with a
// valid bit and local backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_stage (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  b2da_pkg::dabble_state_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output b2da_pkg::dabble_state_t out_data
);

  b2da_pkg::dabble_state_t data_next;

  always_comb begin
    data_next = in_data;
    for (int s = 0; s < b2da_pkg::STEPS_PER_STAGE; s++) begin
      data_next = b2da_pkg::dabble_step(data_next);
    end
  end

  // bubbles collapse: an empty stage always takes a request
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: design/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned 32-bit number to decimal ASCII digits, most
// significant first, without leading zeros; tlast marks the final digit.
//
//   channel  dir  tdata                  tuser  tlast
//   s_*      in   [31:0] value           -      -
//   m_*      out  [5:0] digit_char       -      last_digit
//
// Eight-stage double-dabble pipeline (four bits per stage), then a digit
// emitter. Each number holds the output for one transfer per digit, 1 to 10
// digits: the single character port sets the sustained rate. Pipeline stages
// keep filling while the emitter drains. Reset (rst, synchronous) empties
// all stages and the emitter. Stalls on m_tready back up stage by stage;
// nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire  [b2da_pkg::VALUE_W-1:0]         s_tdata,   // [31:0] value
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [b2da_pkg::TDATA_OUT_W-1:0]     m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic                                 m_tlast    // last_digit
);

  localparam int NS = b2da_pkg::NUM_STAGES;

  logic                    stage_valid [NS+1];
  logic                    stage_ready [NS+1];
  b2da_pkg::dabble_state_t stage_data  [NS+1];

  assign stage_valid[0] = s_tvalid;
  assign stage_data[0]  = {{b2da_pkg::BCD_W{1'b0}}, s_tdata};
  assign s_tready       = stage_ready[0];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    b2da_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  // digit emitter
  logic                               active;
  logic [3:0]                         digits [b2da_pkg::NUM_DIGITS];
  logic [b2da_pkg::DIGIT_IDX_W-1:0]   idx;
  logic [b2da_pkg::DIGIT_IDX_W-1:0]   lead_idx;
  logic                               load;
  logic                               at_last;

  assign at_last        = (idx == '0);
  assign stage_ready[NS] = !active || (m_tready && at_last);
  assign load           = stage_valid[NS] && stage_ready[NS];

  // highest nonzero digit; zero value falls back to the ones digit
  always_comb begin
    lead_idx = '0;
    for (int j = 0; j < b2da_pkg::NUM_DIGITS; j++) begin
      if (stage_data[NS][b2da_pkg::VALUE_W + 4*j +: 4] != 4'd0) begin
        lead_idx = b2da_pkg::DIGIT_IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (active && m_tready && at_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx <= lead_idx;
      for (int j = 0; j < b2da_pkg::NUM_DIGITS; j++) begin
        digits[j] <= stage_data[NS][b2da_pkg::VALUE_W + 4*j +: 4];
      end
    end else if (active && m_tready && !at_last) begin
      idx <= idx - 1'b1;
    end
  end

  assign m_tvalid = active;
  assign m_tlast  = at_last;
  assign m_tdata  = {{(b2da_pkg::TDATA_OUT_W - b2da_pkg::CHAR_W){1'b0}},
                     b2da_pkg::ASCII_ZERO + {2'b00, digits[idx]}};

endmodule

`default_nettype wire

// File: tb/decimal_digit_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_digit_monitor
// Watches both stream channels of the binary to decimal ASCII unit. Every
// accepted request is turned into its expected decimal digits, which are then
// matched in order against the digits that leave the block.
// ----------------------------------------------------------------------------

module decimal_digit_monitor (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  input  wire                                s_tready,
  input  wire  [b2da_pkg::VALUE_W-1:0]       s_tdata,   // [31:0] value
  input  wire                                m_tvalid,
  input  wire                                m_tready,
  input  wire  [b2da_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [5:0] digit_char, [7:6] zero
  input  wire                                m_tlast,   // last_digit
  output int                                 fail_count,
  output int                                 digits_pending
);

  typedef struct packed {
    logic [b2da_pkg::TDATA_OUT_W-1:0] code;
    logic                             last;
  } digit_t;

  digit_t digit_queue[$];

  // Decimal text of v, most significant digit first, no leading zeros.
  task automatic queue_decimal_digits(input logic [b2da_pkg::VALUE_W-1:0] v);
    logic [3:0]                      lsd_first[b2da_pkg::NUM_DIGITS];
    logic [b2da_pkg::VALUE_W-1:0]    rest;
    int                              count;
    digit_t                          d;
    rest  = v;
    count = 0;
    do begin
      lsd_first[count] = 4'(rest % 10);
      rest             = rest / 10;
      count++;
    end while (rest != 0 && count < b2da_pkg::NUM_DIGITS);
    for (int k = 0; k < count; k++) begin
      d.code = b2da_pkg::TDATA_OUT_W'(b2da_pkg::ASCII_ZERO +
                                      b2da_pkg::CHAR_W'(lsd_first[count-1-k]));
      d.last = (k == count - 1);
      digit_queue.push_back(d);
    end
  endtask

  always @(posedge clk) begin
    digit_t want;
    if (!rst) begin
      // drain side first so a digit never matches one queued this same edge
      if (m_tvalid && m_tready) begin
        if (digit_queue.size() == 0) begin
          $display("%0t: unexpected digit, expected none, got %h last %b",
                   $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = digit_queue.pop_front();
          if (m_tdata !== want.code || m_tlast !== want.last) begin
            $display("%0t: digit mismatch, expected %h last %b, got %h last %b",
                     $time, want.code, want.last, m_tdata, m_tlast);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        queue_decimal_digits(s_tdata);
      end
    end
    digits_pending = digit_queue.size();
  end

endmodule

// File: tb/tb_binary_to_decimal_ascii_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii_unit
// Drives numbers into the binary to decimal ASCII unit: a directed set of
// edge values, then random numbers spread over all digit counts. Both sides
// idle in random bursts, and the sink holds off once long enough to back the
// pipeline up into the input. The monitor checks every digit.
// ----------------------------------------------------------------------------

module tb_binary_to_decimal_ascii_unit;

  localparam int RANDOM_REQUESTS = 160;
  localparam int CALM_FROM       = 140;   // no idling from this request on
  localparam int HOLD_AT         = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 30;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [b2da_pkg::VALUE_W-1:0]        s_tdata;
  logic                                m_tvalid;
  logic                                m_tready;
  logic [b2da_pkg::TDATA_OUT_W-1:0]    m_tdata;
  logic                                m_tlast;

  int   fail_count;
  int   digits_pending;
  int   quiet_cycles;
  logic calm;
  logic hold_req;
  logic hold_done;

  logic [b2da_pkg::VALUE_W-1:0] directed_values[20] = '{
    32'd0,          32'd1,          32'd9,          32'd10,
    32'd99,         32'd100,        32'd999999999,  32'd1000000000,
    32'd4294967295, 32'd4294967294, 32'd2147483648, 32'd2147483647,
    32'h5555_5555,  32'hAAAA_AAAA,  32'd123456789,  32'd4000000000,
    32'd1999999999, 32'd10000,      32'd65535,      32'd4294967290
  };

  binary_to_decimal_ascii_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  decimal_digit_monitor u_monitor (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .fail_count     (fail_count),
    .digits_pending (digits_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly numbers of a random digit count, some raw words and zeros.
  function automatic logic [b2da_pkg::VALUE_W-1:0] pick_value();
    int unsigned n;
    longint      lo;
    longint      hi;
    if ($urandom_range(0, 19) == 0) return '0;
    if ($urandom_range(0, 9) == 0) return $urandom;
    n  = $urandom_range(1, 10);
    lo = 1;
    for (int k = 1; k < n; k++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return b2da_pkg::VALUE_W'(lo + (longint'($urandom) % (hi - lo + 1)));
  endfunction

  task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] v);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  // Random source gap; tdata carries junk while tvalid is low.
  task automatic maybe_idle_source();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Sink: random stall bursts, plus one long hold-off on request.
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) begin
      maybe_idle_source();
      send_value(directed_values[i]);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == CALM_FROM) calm = 1'b1;
      maybe_idle_source();
      send_value(pick_value());
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (digits_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && digits_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
